// ===== design/lfu_pkg.sv =====
// Shared constants for the LFU cache replacement unit.
// No dependencies. Imported by lfu_cell and lfu_cache_replacement_unit.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [2:0]       ADDR_CAPACITY = 3'd0;
    localparam logic [CAP_W-1:0] CAP_RESET     = 5'd16;
endpackage
`default_nettype wire

// ===== design/lfu_cell.sv =====
// One entry of the LFU store: holds key, value, use count and recency rank,
// inspects the search token passing by and applies the broadcast update.
// Depends on lfu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 16,
    parameter int TW  = 4 + 2 * 32 + 32 + 16 + 5 * 4,
    parameter int UW  = 4 + 5 * 4 + 32 + 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [TW-1:0] i_tok,
    output logic      [TW-1:0] o_tok,
    input  wire logic [UW-1:0] i_upd
);
    import lfu_pkg::*;

    typedef struct packed {
        logic             act;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic [IW-1:0]    hit_idx;
        logic [VAL_W-1:0] hit_val;
        logic [IW-1:0]    hit_rank;
        logic             vic_ok;
        logic [IW-1:0]    vic_idx;
        logic [KEY_W-1:0] vic_key;
        logic [CW-1:0]    vic_cnt;
        logic [IW-1:0]    vic_rank;
        logic             free_ok;
        logic [IW-1:0]    free_idx;
    } t_tok;

    typedef struct packed {
        logic             hit;
        logic             put;
        logic [IW-1:0]    hit_idx;
        logic [IW-1:0]    hit_rank;
        logic             evict;
        logic [IW-1:0]    vic_idx;
        logic [IW-1:0]    vic_rank;
        logic             ins;
        logic [IW-1:0]    ins_idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_upd;

    localparam logic [IW-1:0] ME = IW'(IDX);

    t_tok tin;
    t_tok n_tok;
    t_tok r_tok;
    t_upd upd;

    logic             r_valid;
    logic [IW-1:0]    r_rank;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [CW-1:0]    r_cnt;
    logic             is_ins;
    logic             is_vic;

    assign tin   = t_tok'(i_tok);
    assign upd   = t_upd'(i_upd);
    assign o_tok = TW'(r_tok);

    always_comb begin
        n_tok = tin;
        if (tin.act) begin
            if (r_valid && r_key == tin.key && !tin.hit) begin
                n_tok.hit      = 1'b1;
                n_tok.hit_idx  = ME;
                n_tok.hit_val  = r_value;
                n_tok.hit_rank = r_rank;
            end
            if (r_valid && (!tin.vic_ok || r_cnt < tin.vic_cnt ||
                            (r_cnt == tin.vic_cnt && r_rank > tin.vic_rank))) begin
                n_tok.vic_ok   = 1'b1;
                n_tok.vic_idx  = ME;
                n_tok.vic_key  = r_key;
                n_tok.vic_cnt  = r_cnt;
                n_tok.vic_rank = r_rank;
            end
            if (!r_valid && !tin.free_ok) begin
                n_tok.free_ok  = 1'b1;
                n_tok.free_idx = ME;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign is_ins = upd.ins && upd.ins_idx == ME;
    assign is_vic = upd.evict && upd.vic_idx == ME;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (upd.hit) begin
            if (upd.hit_idx == ME) begin
                r_rank <= '0;
            end else if (r_valid && r_rank < upd.hit_rank) begin
                r_rank <= r_rank + 1'b1;
            end
        end else if (is_ins) begin
            r_valid <= 1'b1;
            r_rank  <= '0;
        end else if (is_vic) begin
            r_valid <= 1'b0;
        end else if (r_valid) begin
            r_rank <= r_rank - IW'(upd.evict && r_rank > upd.vic_rank) + IW'(upd.ins);
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd.hit && upd.hit_idx == ME) begin
            if (r_cnt != '1) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (upd.put) begin
                r_value <= upd.value;
            end
        end else if (!upd.hit && is_ins) begin
            r_key   <= upd.key;
            r_value <= upd.value;
            r_cnt   <= '0;
        end
    end
endmodule
`default_nettype wire

// ===== design/lfu_cache_replacement_unit.sv =====
// Top level of the LFU cache replacement unit: stream ports, APB register,
// control sequencer and the chain of lfu_cell entries. Depends on lfu_pkg, lfu_cell.
`timescale 1ns / 1ps
`default_nettype none
// A request is accepted while idle; its search token walks the chain of entry cells,
// one cell per cycle, collecting the matching entry, the eviction victim and the first
// free slot. The update is then broadcast to every cell, waiting while the output
// register still holds an unread result. The next request is taken once the update
// is done; a finished result waits in the output register without blocking it.
// Capacity is written through APB at address 0 and is read as each update commits.
module lfu_cache_replacement_unit #(
    parameter int ENTRIES     = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [63:0] i_s_axis_tdata,  // key[31:0], value_in[63:32]
    input  wire logic        i_s_axis_tuser,  // cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // hit[0], value_out[32:1], evicted[33], evicted_key[65:34], zero fill
    output logic      [71:0] o_m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import lfu_pkg::*;

    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = COUNT_WIDTH;
    localparam int OW  = $clog2(ENTRIES + 1);
    localparam int CPW = (OW > CAP_W) ? OW : CAP_W;
    localparam int TW  = 4 + 2 * KEY_W + VAL_W + CW + 5 * IW;
    localparam int UW  = 4 + 5 * IW + KEY_W + VAL_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    typedef struct packed {
        logic             act;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic [IW-1:0]    hit_idx;
        logic [VAL_W-1:0] hit_val;
        logic [IW-1:0]    hit_rank;
        logic             vic_ok;
        logic [IW-1:0]    vic_idx;
        logic [KEY_W-1:0] vic_key;
        logic [CW-1:0]    vic_cnt;
        logic [IW-1:0]    vic_rank;
        logic             free_ok;
        logic [IW-1:0]    free_idx;
    } t_tok;

    typedef struct packed {
        logic             hit;
        logic             put;
        logic [IW-1:0]    hit_idx;
        logic [IW-1:0]    hit_rank;
        logic             evict;
        logic [IW-1:0]    vic_idx;
        logic [IW-1:0]    vic_rank;
        logic             ins;
        logic [IW-1:0]    ins_idx;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_upd;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic             r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [CAP_W-1:0] r_cap;
    logic [OW-1:0]    r_occ;
    t_tok             r_fin;
    logic             r_out_valid;
    logic             r_hit;
    logic [VAL_W-1:0] r_vout;
    logic             r_ev;
    logic [KEY_W-1:0] r_evk;

    logic [TW-1:0] chain [ENTRIES+1];
    t_tok          inj;
    t_tok          tail;
    t_upd          upd;
    logic          accept;
    logic          fire;
    logic          cap_zero;
    logic          put_miss;
    logic          full;
    logic [CPW-1:0] cap_eff;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && paddr == ADDR_CAPACITY;
    assign prdata = (paddr == ADDR_CAPACITY) ? {{(32 - CAP_W){1'b0}}, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        inj     = '0;
        inj.act = accept;
        inj.key = i_s_axis_tdata[KEY_W-1:0];
    end

    assign chain[0] = TW'(inj);
    assign tail     = t_tok'(chain[ENTRIES]);

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .IDX(g),
            .IW (IW),
            .CW (CW),
            .TW (TW),
            .UW (UW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (chain[g]),
            .o_tok  (chain[g+1]),
            .i_upd  (UW'(upd))
        );
    end

    assign fire     = r_state == S_COMMIT && (!r_out_valid || i_m_axis_tready);
    assign cap_zero = r_cap == '0;
    assign cap_eff  = (CPW'(r_cap) > CPW'(ENTRIES)) ? CPW'(ENTRIES) : CPW'(r_cap);
    assign full     = CPW'(r_occ) >= cap_eff || r_occ == OW'(ENTRIES);
    assign put_miss = fire && !cap_zero && !r_fin.hit && r_cmd == CMD_PUT;

    always_comb begin
        upd          = '0;
        upd.hit      = fire && !cap_zero && r_fin.hit;
        upd.put      = r_cmd == CMD_PUT;
        upd.hit_idx  = r_fin.hit_idx;
        upd.hit_rank = r_fin.hit_rank;
        upd.evict    = put_miss && full && r_fin.vic_ok;
        upd.vic_idx  = r_fin.vic_idx;
        upd.vic_rank = r_fin.vic_rank;
        upd.ins      = put_miss && (r_fin.free_ok || upd.evict);
        if (upd.evict && (!r_fin.free_ok || r_fin.vic_idx < r_fin.free_idx)) begin
            upd.ins_idx = r_fin.vic_idx;
        end else begin
            upd.ins_idx = r_fin.free_idx;
        end
        upd.key      = r_fin.key;
        upd.value    = r_val;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (tail.act) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= r_occ - OW'(upd.evict) + OW'(upd.ins);
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_s_axis_tuser;
            r_val <= i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (r_state == S_SCAN && tail.act) begin
            r_fin <= tail;
        end
        if (fire) begin
            r_hit  <= upd.hit;
            r_vout <= (upd.hit && r_cmd == CMD_GET) ? r_fin.hit_val : '0;
            r_ev   <= upd.evict;
            r_evk  <= upd.evict ? r_fin.vic_key : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_evk, r_ev, r_vout, r_hit};
endmodule
`default_nettype wire
